### rtl/core/hrp_pkg.sv
// Shared types, character constants and byte classifiers for the HTTP request header parser.
`default_nettype none

package hrp_pkg;

    // Default accumulator width for the version numbers
    localparam int unsigned VERSION_BITS_DEF = 8;

    // Character codes used by the parser
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CTL_MAX  = 8'h1F;

    typedef enum logic [4:0] {
        ST_METHOD_START = 5'd0,
        ST_METHOD       = 5'd1,
        ST_URI          = 5'd2,
        ST_VER_H        = 5'd3,
        ST_VER_T1       = 5'd4,
        ST_VER_T2       = 5'd5,
        ST_VER_P        = 5'd6,
        ST_VER_SLASH    = 5'd7,
        ST_MAJOR_START  = 5'd8,
        ST_MAJOR        = 5'd9,
        ST_MINOR_START  = 5'd10,
        ST_MINOR        = 5'd11,
        ST_NL1          = 5'd12,
        ST_LINE_START   = 5'd13,
        ST_LWS          = 5'd14,
        ST_NAME         = 5'd15,
        ST_SPACE_VALUE  = 5'd16,
        ST_VALUE        = 5'd17,
        ST_NL2          = 5'd18,
        ST_NL3          = 5'd19
    } t_parse_state;

    typedef enum logic [1:0] {
        STAT_PENDING = 2'd0,
        STAT_GOOD    = 2'd1,
        STAT_BAD     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ROLE_NONE   = 3'd0,
        ROLE_METHOD = 3'd1,
        ROLE_URI    = 3'd2,
        ROLE_NAME   = 3'd3,
        ROLE_VALUE  = 3'd4
    } t_role;

    // Input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_hrp_in;

    // Result transaction
    typedef struct packed {
        t_status    status;
        t_role      byte_role;
        logic       header_start;
        logic [7:0] echo_byte;
        logic [7:0] major_version;
        logic [7:0] minor_version;
    } t_hrp_out;

    // Parser control context carried between the state registers and the step logic
    typedef struct packed {
        t_parse_state state;
        logic         hdr_seen;
    } t_hrp_ctx;

    // Control characters: 0..31 and DEL
    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CTL_MAX) || (b == CH_DEL);
    endfunction

    // Token separators
    function automatic logic is_sep(input logic [7:0] b);
        logic r;
        case (b)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
            8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
            8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
            default:                    r = 1'b0;
        endcase
        return r;
    endfunction

    // Token character: 7-bit, neither control nor separator
    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !is_sep(b);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

endpackage

`default_nettype wire

### rtl/core/http_request_header_parser_top.sv
// Top level of the byte-at-a-time HTTP/1.x request header parser.
//
// Usage: stream request bytes on the input channel (valid/ready), one byte per
// transaction, with restart set on the first byte of a new request to return
// the parser to the method start. Each input transaction yields exactly one
// result transaction carrying status (pending, good, bad), the byte's role,
// a header start flag, the echoed byte and the running version numbers.
// Path: an input register, then the state step and a result register.
// Throughput is one byte per cycle while the receiver does not stall; the
// parser state updates as a byte moves from the input register to the
// result register.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the method start with the version numbers at zero. When the
// receiver stalls, the result register holds, the input register fills, and
// input ready drops once both are occupied; no transaction is lost.
`default_nettype none

module http_request_header_parser_top #(
    parameter int unsigned VERSION_BITS = hrp_pkg::VERSION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire hrp_pkg::t_hrp_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output hrp_pkg::t_hrp_out      o_out_data
);
    import hrp_pkg::*;

    localparam int unsigned AW = VERSION_BITS + 4;

    logic                    r_in_valid;
    t_hrp_in                 r_in;
    logic                    r_out_valid;
    t_hrp_out                r_out;
    t_hrp_ctx                r_ctx;
    logic [VERSION_BITS-1:0] r_major;
    logic [VERSION_BITS-1:0] r_minor;

    t_hrp_ctx                n_ctx;
    logic [VERSION_BITS-1:0] n_major;
    logic [VERSION_BITS-1:0] n_minor;
    t_status                 n_status;
    t_role                   n_role;
    logic                    n_hs;
    logic                    advance;
    logic                    fire;
    logic [AW-1:0]           major_ext;
    logic [AW-1:0]           minor_ext;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    hrp_step #(
        .VERSION_BITS (VERSION_BITS)
    ) u_step (
        .i_byte         (r_in.data_byte),
        .i_restart      (r_in.restart),
        .i_ctx          (r_ctx),
        .i_major        (r_major),
        .i_minor        (r_minor),
        .o_ctx          (n_ctx),
        .o_major        (n_major),
        .o_minor        (n_minor),
        .o_status       (n_status),
        .o_role         (n_role),
        .o_header_start (n_hs)
    );

    assign major_ext = {{4{1'b0}}, n_major};
    assign minor_ext = {{4{1'b0}}, n_minor};

    // Capture an input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Advance the parser state as the byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state    <= ST_METHOD_START;
            r_ctx.hdr_seen <= 1'b0;
            r_major        <= '0;
            r_minor        <= '0;
        end else if (fire) begin
            r_ctx   <= n_ctx;
            r_major <= n_major;
            r_minor <= n_minor;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_out.status        <= n_status;
            r_out.byte_role     <= n_role;
            r_out.header_start  <= n_hs;
            r_out.echo_byte     <= r_in.data_byte;
            r_out.major_version <= major_ext[7:0];
            r_out.minor_version <= minor_ext[7:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A bad byte carries no role and no header start
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STAT_BAD)) |->
        ((o_out_data.byte_role == ROLE_NONE) && !o_out_data.header_start))
        else $error("bad result carries a role or header start");

    // Header start only on a header name byte
    a_hs_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.header_start) |->
        (o_out_data.byte_role == ROLE_NAME))
        else $error("header start without header name role");

    // Completion is reported only on a line feed
    a_good_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STAT_GOOD)) |->
        (o_out_data.echo_byte == CH_LF))
        else $error("good status on a byte other than LF");

    // An empty result register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

### rtl/core/hrp_step.sv
// Per-byte next-state, version accumulation and result decode for the request parser.
`default_nettype none

module hrp_step #(
    parameter int unsigned VERSION_BITS = hrp_pkg::VERSION_BITS_DEF
) (
    input  wire logic [7:0]              i_byte,
    input  wire logic                    i_restart,
    input  wire hrp_pkg::t_hrp_ctx       i_ctx,
    input  wire logic [VERSION_BITS-1:0] i_major,
    input  wire logic [VERSION_BITS-1:0] i_minor,
    output hrp_pkg::t_hrp_ctx            o_ctx,
    output logic [VERSION_BITS-1:0]      o_major,
    output logic [VERSION_BITS-1:0]      o_minor,
    output hrp_pkg::t_status             o_status,
    output hrp_pkg::t_role               o_role,
    output logic                         o_header_start
);
    import hrp_pkg::*;

    // Wide enough for acc*10+9 before saturation
    localparam int unsigned AW = VERSION_BITS + 4;
    localparam logic [AW-1:0] VMAX = {{4{1'b0}}, {VERSION_BITS{1'b1}}};

    t_parse_state            cur_state;
    logic                    cur_seen;
    logic [VERSION_BITS-1:0] cur_major;
    logic [VERSION_BITS-1:0] cur_minor;
    t_parse_state            nx_state;
    logic                    nx_seen;
    logic                    ok;
    logic                    sp_or_tab;
    t_status                 st_raw;
    t_role                   role_raw;
    logic                    hs_raw;

    // Saturating decimal accumulate: acc*10 + digit
    function automatic logic [VERSION_BITS-1:0] sat_acc(
        input logic [VERSION_BITS-1:0] acc,
        input logic [7:0]              b
    );
        logic [AW-1:0] ext;
        logic [AW-1:0] sum;
        ext = {{4{1'b0}}, acc};
        sum = (ext << 3) + (ext << 1) + AW'(b - CH_0);
        return (sum > VMAX) ? VERSION_BITS'(VMAX) : sum[VERSION_BITS-1:0];
    endfunction

    // Apply restart before the byte is consumed
    assign cur_state = i_restart ? ST_METHOD_START : i_ctx.state;
    assign cur_seen  = i_restart ? 1'b0 : i_ctx.hdr_seen;
    assign cur_major = i_restart ? '0 : i_major;
    assign cur_minor = i_restart ? '0 : i_minor;
    assign sp_or_tab = (i_byte == CH_SP) || (i_byte == CH_TAB);

    // Next state and byte acceptance
    always_comb begin
        nx_state = cur_state;
        nx_seen  = cur_seen;
        ok       = 1'b1;
        unique case (cur_state)
            ST_METHOD_START: begin
                if (is_token(i_byte)) nx_state = ST_METHOD;
                else ok = 1'b0;
            end
            ST_METHOD: begin
                if (i_byte == CH_SP) nx_state = ST_URI;
                else if (!is_token(i_byte)) ok = 1'b0;
            end
            ST_URI: begin
                if (i_byte == CH_SP) nx_state = ST_VER_H;
                else if (is_ctl(i_byte)) ok = 1'b0;
            end
            ST_VER_H: begin
                if (i_byte == CH_H) nx_state = ST_VER_T1;
                else ok = 1'b0;
            end
            ST_VER_T1: begin
                if (i_byte == CH_T) nx_state = ST_VER_T2;
                else ok = 1'b0;
            end
            ST_VER_T2: begin
                if (i_byte == CH_T) nx_state = ST_VER_P;
                else ok = 1'b0;
            end
            ST_VER_P: begin
                if (i_byte == CH_P) nx_state = ST_VER_SLASH;
                else ok = 1'b0;
            end
            ST_VER_SLASH: begin
                if (i_byte == CH_SLASH) nx_state = ST_MAJOR_START;
                else ok = 1'b0;
            end
            ST_MAJOR_START: begin
                if (is_digit(i_byte)) nx_state = ST_MAJOR;
                else ok = 1'b0;
            end
            ST_MAJOR: begin
                if (i_byte == CH_DOT) nx_state = ST_MINOR_START;
                else if (!is_digit(i_byte)) ok = 1'b0;
            end
            ST_MINOR_START: begin
                if (is_digit(i_byte)) nx_state = ST_MINOR;
                else ok = 1'b0;
            end
            ST_MINOR: begin
                if (i_byte == CH_CR) nx_state = ST_NL1;
                else if (!is_digit(i_byte)) ok = 1'b0;
            end
            ST_NL1: begin
                if (i_byte == CH_LF) nx_state = ST_LINE_START;
                else ok = 1'b0;
            end
            ST_LINE_START: begin
                if (i_byte == CH_CR) nx_state = ST_NL3;
                else if (cur_seen && sp_or_tab) nx_state = ST_LWS;
                else if (is_token(i_byte)) begin
                    nx_state = ST_NAME;
                    nx_seen  = 1'b1;
                end else ok = 1'b0;
            end
            ST_LWS: begin
                if (i_byte == CH_CR) nx_state = ST_NL2;
                else if (sp_or_tab) nx_state = ST_LWS;
                else if (is_ctl(i_byte)) ok = 1'b0;
                else nx_state = ST_VALUE;
            end
            ST_NAME: begin
                if (i_byte == CH_COLON) nx_state = ST_SPACE_VALUE;
                else if (!is_token(i_byte)) ok = 1'b0;
            end
            ST_SPACE_VALUE: begin
                if (i_byte == CH_SP) nx_state = ST_VALUE;
                else ok = 1'b0;
            end
            ST_VALUE: begin
                if (i_byte == CH_CR) nx_state = ST_NL2;
                else if (is_ctl(i_byte)) ok = 1'b0;
            end
            ST_NL2: begin
                if (i_byte == CH_LF) nx_state = ST_LINE_START;
                else ok = 1'b0;
            end
            ST_NL3: begin
                if (i_byte != CH_LF) ok = 1'b0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Hold the state on a bad byte (restart still takes effect)
    always_comb begin
        o_ctx.state    = ok ? nx_state : cur_state;
        o_ctx.hdr_seen = ok ? nx_seen : cur_seen;
    end

    // Version accumulators: clear on the slash, accumulate digits
    always_comb begin
        o_major = cur_major;
        o_minor = cur_minor;
        case (cur_state) inside
            ST_VER_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    o_major = '0;
                    o_minor = '0;
                end
            end
            ST_MAJOR_START, ST_MAJOR: begin
                if (is_digit(i_byte)) o_major = sat_acc(cur_major, i_byte);
            end
            ST_MINOR_START, ST_MINOR: begin
                if (is_digit(i_byte)) o_minor = sat_acc(cur_minor, i_byte);
            end
            default: begin
                o_major = cur_major;
            end
        endcase
    end

    // Byte role, header start and completion decode
    always_comb begin
        st_raw   = STAT_PENDING;
        role_raw = ROLE_NONE;
        hs_raw   = 1'b0;
        unique case (cur_state)
            ST_METHOD_START: role_raw = ROLE_METHOD;
            ST_METHOD: begin
                if (is_token(i_byte)) role_raw = ROLE_METHOD;
            end
            ST_URI: begin
                if ((i_byte != CH_SP) && !is_ctl(i_byte)) role_raw = ROLE_URI;
            end
            ST_LINE_START: begin
                if (is_token(i_byte)) begin
                    role_raw = ROLE_NAME;
                    hs_raw   = 1'b1;
                end
            end
            ST_LWS: begin
                if ((i_byte != CH_SP) && !is_ctl(i_byte)) role_raw = ROLE_VALUE;
            end
            ST_NAME: begin
                if (is_token(i_byte)) role_raw = ROLE_NAME;
            end
            ST_VALUE: begin
                if (!is_ctl(i_byte)) role_raw = ROLE_VALUE;
            end
            ST_NL3: st_raw = STAT_GOOD;
            default: role_raw = ROLE_NONE;
        endcase
    end

    // Drop role and header start on a bad byte
    assign o_status       = ok ? st_raw : STAT_BAD;
    assign o_role         = ok ? role_raw : ROLE_NONE;
    assign o_header_start = ok && hs_raw;

endmodule

`default_nettype wire
